@@ hdl/wfba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfba_pkg
// shared codes, field widths and defaults of the worst-fit block allocator
// ----------------------------------------------------------------------------
package wfba_pkg;

  localparam int NUM_BLOCKS_DEF = 16;
  localparam int SIZE_WIDTH_DEF = 16;

  localparam int OP_W     = 2;
  localparam int INDEX_W  = 4;
  localparam int AMOUNT_W = 16;
  localparam int OWNER_W  = 16;
  localparam int STATUS_W = 3;
  localparam int GRANT_W  = 16;

  localparam int IN_DATA_W  = 40;  // index + amount + owner, padded to bytes
  localparam int OUT_DATA_W = 24;  // block number + granted size, padded

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FIT    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FREED     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_LOADED    = 3'd4;

endpackage

@@ hdl/wfba_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfba_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module wfba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/worst_fit_block_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// worst_fit_block_allocator
// table of memory blocks with worst-fit allocation and release by owner
// ----------------------------------------------------------------------------
// One request at a time. A load request passes through the load and result
// states to the output register; allocate and free requests pass through the
// scan, finish and result states, the scan reading one table slot per cycle
// from the size and owner rams through a single compare unit. A result that
// finds the output register still full and unread waits there until the
// register drains. Sizes and owners live in rams, present and taken marks in
// flip-flops cleared by reset, so no clearing pass is needed. The output
// register decouples the result side: once a result sits there, the next
// request is accepted while it waits.
// ----------------------------------------------------------------------------
module worst_fit_block_allocator
  import wfba_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // block_index, amount, owner
  input  logic [OP_W-1:0]       s_axis_tuser,   // operation
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // block_number, granted_size
  output logic [STATUS_W-1:0]   m_axis_tuser    // status
);

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CMP_W = (SIZE_WIDTH > AMOUNT_W) ? SIZE_WIDTH : AMOUNT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_FINISH = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0] state;

  // latched request
  logic [OP_W-1:0]     op_q;
  logic [INDEX_W-1:0]  idx_q;
  logic [AMOUNT_W-1:0] amt_q;
  logic [OWNER_W-1:0]  who_q;

  // slot marks
  logic [NUM_BLOCKS-1:0] slot_present;
  logic [NUM_BLOCKS-1:0] slot_taken;

  // scan control
  logic [IDX_W-1:0] scan_cnt;
  logic             issue;
  logic             eval_vld;
  logic [IDX_W-1:0] eval_idx;

  // best candidate so far
  logic                  found;
  logic [IDX_W-1:0]      best_idx;
  logic [SIZE_WIDTH-1:0] best_size;

  // prepared result
  logic [STATUS_W-1:0] res_status;
  logic [INDEX_W-1:0]  res_block;
  logic [GRANT_W-1:0]  res_size;

  // output register
  logic [STATUS_W-1:0] out_status;
  logic [INDEX_W-1:0]  out_block;
  logic [GRANT_W-1:0]  out_size;

  // ram ports
  logic                  size_we;
  logic [IDX_W-1:0]      size_waddr;
  logic [SIZE_WIDTH-1:0] size_wdata;
  logic [SIZE_WIDTH-1:0] rd_size;
  logic                  owner_we;
  logic [OWNER_W-1:0]    rd_owner;

  logic in_accept;
  logic idx_ok;
  logic [IDX_W-1:0] load_addr;
  logic cand_alloc;
  logic cand_free;
  logic take;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);

  // load targets only slots that exist
  assign idx_ok    = (32'(idx_q) < 32'(NUM_BLOCKS));
  assign load_addr = IDX_W'(idx_q);

  // shared compare unit, applied to the slot read in the previous cycle
  always_comb begin
    cand_alloc = slot_present[eval_idx] && !slot_taken[eval_idx] &&
                 (CMP_W'(rd_size) >= CMP_W'(amt_q));
    cand_free  = slot_present[eval_idx] && slot_taken[eval_idx] &&
                 (rd_owner == who_q);
    if (op_q == OP_ALLOC) begin
      take = cand_alloc && (!found || (rd_size > best_size));
    end else begin
      take = cand_free && !found;  // first owner match wins
    end
  end

  always_comb begin
    size_we    = (state == S_LOAD) && idx_ok;
    size_waddr = load_addr;
    size_wdata = SIZE_WIDTH'(amt_q);
    owner_we   = (state == S_FINISH) && (op_q == OP_ALLOC) && found;
  end

  wfba_ram #(
    .WIDTH (SIZE_WIDTH),
    .DEPTH (NUM_BLOCKS)
  ) u_size_ram (
    .clk     (clk),
    .wr_en   (size_we),
    .wr_addr (size_waddr),
    .wr_data (size_wdata),
    .rd_addr (scan_cnt),
    .rd_data (rd_size)
  );

  wfba_ram #(
    .WIDTH (OWNER_W),
    .DEPTH (NUM_BLOCKS)
  ) u_owner_ram (
    .clk     (clk),
    .wr_en   (owner_we),
    .wr_addr (best_idx),
    .wr_data (who_q),
    .rd_addr (scan_cnt),
    .rd_data (rd_owner)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      slot_present  <= '0;
      slot_taken    <= '0;
      issue         <= 1'b0;
      eval_vld      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // output register drains independently of the sequencer
      if (m_axis_tvalid && m_axis_tready && (state != S_RESULT)) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            op_q      <= s_axis_tuser;
            idx_q     <= s_axis_tdata[INDEX_W-1:0];
            amt_q     <= s_axis_tdata[INDEX_W +: AMOUNT_W];
            who_q     <= s_axis_tdata[INDEX_W+AMOUNT_W +: OWNER_W];
            found     <= 1'b0;
            best_idx  <= '0;
            best_size <= '0;
            scan_cnt  <= '0;
            unique case (s_axis_tuser)
              OP_LOAD: begin
                state <= S_LOAD;
              end
              OP_ALLOC, OP_FREE: begin
                issue <= 1'b1;
                state <= S_SCAN;
              end
              default: begin
                // undefined operation: table left unchanged, reported as not found
                res_status <= ST_NOT_FOUND;
                res_block  <= '0;
                res_size   <= '0;
                state      <= S_RESULT;
              end
            endcase
          end
        end

        S_LOAD: begin
          res_status <= ST_LOADED;
          res_block  <= idx_q;
          if (idx_ok) begin
            slot_present[load_addr] <= 1'b1;
            slot_taken[load_addr]   <= 1'b0;  // reload drops any allocation
            res_size <= GRANT_W'(SIZE_WIDTH'(amt_q));
          end else begin
            res_size <= '0;
          end
          state <= S_RESULT;
        end

        S_SCAN: begin
          // read issue runs one slot ahead of evaluation; issue is already
          // low when the last slot is evaluated, so eval_vld drops with it
          eval_vld <= issue;
          eval_idx <= scan_cnt;
          if (issue) begin
            if (scan_cnt == LAST_IDX) begin
              issue <= 1'b0;
            end else begin
              scan_cnt <= scan_cnt + 1'b1;
            end
          end
          if (eval_vld) begin
            if (take) begin
              found     <= 1'b1;
              best_idx  <= eval_idx;
              best_size <= rd_size;
            end
            if (eval_idx == LAST_IDX) begin
              state <= S_FINISH;
            end
          end
        end

        S_FINISH: begin
          if (found) begin
            res_block <= INDEX_W'(best_idx);
            res_size  <= GRANT_W'(best_size);
            if (op_q == OP_ALLOC) begin
              slot_taken[best_idx] <= 1'b1;
              res_status <= ST_ALLOCATED;
            end else begin
              slot_taken[best_idx] <= 1'b0;
              res_status <= ST_FREED;
            end
          end else begin
            res_block  <= '0;
            res_size   <= '0;
            res_status <= (op_q == OP_ALLOC) ? ST_NO_FIT : ST_NOT_FOUND;
          end
          state <= S_RESULT;
        end

        S_RESULT: begin
          // wait for room in the output register
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            out_status    <= res_status;
            out_block     <= res_block;
            out_size      <= res_size;
            state         <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {{(OUT_DATA_W - INDEX_W - GRANT_W){1'b0}}, out_size, out_block};

  // one request in flight: no acceptance right after an acceptance
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !s_axis_tready)
    else $error("request accepted while previous one in progress");

  // a granted slot is marked taken
  a_alloc_marks: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && op_q == OP_ALLOC && found) |=> slot_taken[$past(best_idx)])
    else $error("allocated slot not marked taken");

  // a released slot is no longer taken
  a_free_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && op_q == OP_FREE && found) |=> !slot_taken[$past(best_idx)])
    else $error("freed slot still marked taken");

endmodule
